### rtl/core/sine_cosine_unit_core_assert.svh
// ----------------------------------------------------------------------------
// Sine/cosine unit assertion macros
// Shared property wrappers; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef SINE_COSINE_UNIT_CORE_ASSERT_SVH
`define SINE_COSINE_UNIT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge while reset is released.
`define SCU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check prop at every rising edge, reset included.
`define SCU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCU_ASSERT(lbl, clk, rstn, prop, msg)
`define SCU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/scu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine unit package
// Widths, fixed-point constants and the pipeline payload type.
// ----------------------------------------------------------------------------
package scu_pkg;

    // Field and datapath widths
    localparam int unsigned ANGLE_W       = 24;  // input angle, Q8.16
    localparam int unsigned RED_W         = 19;  // angle mod two pi
    localparam int unsigned X_W           = 18;  // folded angle, 0..pi
    localparam int unsigned X2_W          = 28;  // x^2 in Q4.24
    localparam int unsigned X2_SHIFT      = 8;
    localparam int unsigned FRAC_SHIFT    = 14;  // Q16 -> Q30
    localparam int unsigned TERM_W        = 33;  // series term magnitude, Q30
    localparam int unsigned PROD_SHIFT    = 24;
    localparam int unsigned P_W           = 36;  // term * x^2 >> 24
    localparam int unsigned SUM_W         = 36;  // signed Q30 running sum
    localparam int unsigned RECIP_SHIFT   = 37;  // reciprocal scale for exact division
    localparam int unsigned RECIP_W       = 35;
    localparam int unsigned SPLIT_W       = 18;  // partial product split point
    localparam int unsigned RES_W         = 9;   // residue after estimated quotient
    localparam int unsigned OUT_W         = 16;  // Q2.14 results
    localparam int unsigned RND_SHIFT     = 16;  // Q30 -> Q14
    localparam int unsigned ROOT_W        = 15;
    localparam int unsigned RAD_W         = 29;  // radicand 2^28 - s^2
    localparam int unsigned SQRT_STEPS    = 4;   // root bits per stage
    localparam int unsigned SQRT_STAGES   = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int unsigned MOD_STEPS     = 6;   // quotient bits of angle / two pi
    localparam int unsigned MOD_PER_STAGE = 3;

    // Default number of series terms
    localparam int unsigned SCU_TERMS = 4;

    // Angle constants in Q8.16
    localparam logic [RED_W-1:0] PI_Q16            = 19'd205887;
    localparam logic [RED_W-1:0] TWO_PI_Q16        = 19'd411774;
    localparam logic [RED_W-1:0] HALF_PI_Q16       = 19'd102943;
    localparam logic [RED_W-1:0] THREE_HALF_PI_Q16 = 19'd308830;

    localparam logic [ROOT_W-1:0] ONE_Q14    = 15'd16384;
    localparam logic [RAD_W-1:0]  ONE_SQ_Q28 = 29'd268435456;

    // Payload between polynomial stages
    typedef struct packed {
        logic [X2_W-1:0]          x2;
        logic [TERM_W-1:0]        term;
        logic signed [SUM_W-1:0]  sum;
        logic                     neg_s;  // reduced angle above pi
        logic                     neg_c;  // reduced angle strictly in (pi/2, 3pi/2)
    } scu_poly_t;

endpackage

### rtl/core/scu_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine unit angle reduction
// Reduces the angle mod two pi, folds the upper half-turn and seeds the series.
// ----------------------------------------------------------------------------
module scu_reduce
    import scu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ANGLE_W-1:0] in_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output scu_poly_t          out_poly
);

    localparam int unsigned NSTG = 4;
    localparam logic [ANGLE_W-1:0] MOD_BASE = ANGLE_W'(TWO_PI_Q16);

    // Restoring subtraction of two pi multiples, MOD_PER_STAGE quotient bits
    function automatic logic [ANGLE_W-1:0] mod_pass(input logic [ANGLE_W-1:0] v,
                                                    input int unsigned top_sh);
        logic [ANGLE_W-1:0] rem;
        logic [ANGLE_W-1:0] sub;
        rem = v;
        for (int i = 0; i < MOD_PER_STAGE; i++) begin
            sub = MOD_BASE << (top_sh - i);
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem;
    endfunction

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] stg_ready;

    logic [ANGLE_W-1:0] m1_reg;
    logic [RED_W-1:0]   r_reg;
    logic [X_W-1:0]     x_reg;
    logic               neg_s_reg;
    logic               neg_c_reg;
    scu_poly_t          poly_reg;

    logic [ANGLE_W-1:0] m1_next;
    logic [ANGLE_W-1:0] m2_full;
    logic [RED_W-1:0]   r_next;
    logic [X_W-1:0]     x_next;
    logic               neg_s_next;
    logic               neg_c_next;
    logic [2*X_W-1:0]   xx;
    scu_poly_t          poly_next;

    // Stage advances when empty or when the next stage advances
    always_comb begin
        logic dn_ready;
        dn_ready = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            stg_ready[i] = !valid_reg[i] || dn_ready;
            dn_ready     = stg_ready[i];
        end
    end

    always_comb begin
        m1_next    = mod_pass(in_angle, MOD_STEPS - 1);
        m2_full    = mod_pass(m1_reg, MOD_STEPS - 1 - MOD_PER_STAGE);
        r_next     = m2_full[RED_W-1:0];
        neg_s_next = r_reg > PI_Q16;
        x_next     = neg_s_next ? X_W'(r_reg - PI_Q16) : r_reg[X_W-1:0];
        neg_c_next = (r_reg > HALF_PI_Q16) && (r_reg < THREE_HALF_PI_Q16);
        xx                = x_reg * x_reg;
        poly_next.x2      = xx[X2_SHIFT +: X2_W];
        poly_next.term    = TERM_W'(x_reg) << FRAC_SHIFT;
        poly_next.sum     = $signed(SUM_W'(x_reg) << FRAC_SHIFT);
        poly_next.neg_s   = neg_s_reg;
        poly_next.neg_c   = neg_c_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (stg_ready[i]) begin
                    valid_reg[i] <= (i == 0) ? in_valid : valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_ready[0]) begin
            m1_reg <= m1_next;
        end
        if (stg_ready[1]) begin
            r_reg <= r_next;
        end
        if (stg_ready[2]) begin
            x_reg     <= x_next;
            neg_s_reg <= neg_s_next;
            neg_c_reg <= neg_c_next;
        end
        if (stg_ready[3]) begin
            poly_reg <= poly_next;
        end
    end

    assign in_ready  = stg_ready[0];
    assign out_valid = valid_reg[NSTG-1];
    assign out_poly  = poly_reg;

endmodule

### rtl/core/scu_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine unit series term
// Computes term k = ((term * x^2) >> 24) / ((2k)(2k+1)) and adds it to the sum.
// ----------------------------------------------------------------------------
module scu_term
    import scu_pkg::*;
#(
    parameter int unsigned K = 1
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  scu_poly_t in_poly,
    output logic      out_valid,
    input  logic      out_ready,
    output scu_poly_t out_poly
);

    localparam int unsigned NSTG  = 4;
    localparam int unsigned DIV   = (2 * K) * (2 * K + 1);
    localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / DIV;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int unsigned RHI_W = RECIP_W - SPLIT_W;
    localparam int unsigned PHI_W = P_W - SPLIT_W;
    localparam int unsigned ACC_W = P_W + RECIP_W;
    localparam logic [RHI_W-1:0]   RECIP_HI = RECIP[RECIP_W-1:SPLIT_W];
    localparam logic [SPLIT_W-1:0] RECIP_LO = RECIP[SPLIT_W-1:0];
    localparam logic [RES_W-1:0]   DIV_RES  = RES_W'(DIV);
    localparam bit SUB = (K % 2) == 1;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] stg_ready;

    // Stage 1: product
    logic [P_W-1:0] p1_reg;
    scu_poly_t      ctx1_reg;
    // Stage 2: partial products of p * reciprocal
    logic [PHI_W+RHI_W-1:0]     pp_hh_reg;
    logic [PHI_W+SPLIT_W-1:0]   pp_hl_reg;
    logic [SPLIT_W+RHI_W-1:0]   pp_lh_reg;
    logic [2*SPLIT_W-1:0]       pp_ll_reg;
    logic [RES_W-1:0]           p2_low_reg;
    scu_poly_t                  ctx2_reg;
    // Stage 3: quotient estimate
    logic [TERM_W-1:0] q0_reg;
    logic [RES_W-1:0]  p3_low_reg;
    scu_poly_t         ctx3_reg;
    // Stage 4: corrected term and sum
    scu_poly_t poly_reg;

    logic [TERM_W+X2_W-1:0] prod;
    logic [ACC_W-1:0]       acc;
    logic [2*RES_W-1:0]     qd;
    logic [RES_W-1:0]       residue;
    logic [TERM_W-1:0]      q;
    logic signed [SUM_W-1:0] q_ext;
    scu_poly_t              poly_next;

    always_comb begin
        logic dn_ready;
        dn_ready = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            stg_ready[i] = !valid_reg[i] || dn_ready;
            dn_ready     = stg_ready[i];
        end
    end

    always_comb begin
        prod = in_poly.term * in_poly.x2;
        acc  = (ACC_W'(pp_hh_reg) << (2 * SPLIT_W))
             + (ACC_W'(pp_hl_reg) << SPLIT_W)
             + (ACC_W'(pp_lh_reg) << SPLIT_W)
             + ACC_W'(pp_ll_reg);
        // Estimate is exact or one low; the residue decides
        qd      = q0_reg[RES_W-1:0] * DIV_RES;
        residue = p3_low_reg - qd[RES_W-1:0];
        q       = q0_reg + TERM_W'(residue >= DIV_RES);
        q_ext   = $signed(SUM_W'(q));
        poly_next      = ctx3_reg;
        poly_next.term = q;
        poly_next.sum  = SUB ? (ctx3_reg.sum - q_ext) : (ctx3_reg.sum + q_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (stg_ready[i]) begin
                    valid_reg[i] <= (i == 0) ? in_valid : valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_ready[0]) begin
            p1_reg   <= prod[PROD_SHIFT +: P_W];
            ctx1_reg <= in_poly;
        end
        if (stg_ready[1]) begin
            pp_hh_reg  <= p1_reg[P_W-1:SPLIT_W] * RECIP_HI;
            pp_hl_reg  <= p1_reg[P_W-1:SPLIT_W] * RECIP_LO;
            pp_lh_reg  <= p1_reg[SPLIT_W-1:0] * RECIP_HI;
            pp_ll_reg  <= p1_reg[SPLIT_W-1:0] * RECIP_LO;
            p2_low_reg <= p1_reg[RES_W-1:0];
            ctx2_reg   <= ctx1_reg;
        end
        if (stg_ready[2]) begin
            q0_reg     <= acc[RECIP_SHIFT +: TERM_W];
            p3_low_reg <= p2_low_reg;
            ctx3_reg   <= ctx2_reg;
        end
        if (stg_ready[3]) begin
            poly_reg <= poly_next;
        end
    end

    assign in_ready  = stg_ready[0];
    assign out_valid = valid_reg[NSTG-1];
    assign out_poly  = poly_reg;

endmodule

### rtl/core/scu_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine unit finish
// Rounds and saturates the sine, then takes the cosine by integer square root.
// ----------------------------------------------------------------------------
module scu_finish
    import scu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  scu_poly_t               in_poly,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] out_sine,
    output logic signed [OUT_W-1:0] out_cosine
);

    localparam int unsigned NSTG    = 3 + SQRT_STAGES + 1;
    localparam int unsigned SQ0     = 3;
    localparam int unsigned MAG_W   = SUM_W - 1;
    localparam int unsigned RND_W   = SUM_W - RND_SHIFT;
    localparam int unsigned TRIAL_W = RAD_W + 1;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] stg_ready;

    // Stage F1: magnitude
    logic [MAG_W-1:0] mag_reg;
    logic             sgn_reg;
    logic             f1_negc_reg;
    // Stage F2: rounded, saturated sine
    logic signed [OUT_W-1:0] f2_sine_reg;
    logic                    f2_negc_reg;
    // Stage F3: radicand
    logic [RAD_W-1:0]        v_reg;
    logic signed [OUT_W-1:0] f3_sine_reg;
    logic                    f3_negc_reg;
    // Root stages
    logic [RAD_W-1:0]        sq_rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0]       sq_root_reg [SQRT_STAGES];
    logic signed [OUT_W-1:0] sq_sine_reg [SQRT_STAGES];
    logic                    sq_negc_reg [SQRT_STAGES];
    // Output register
    logic signed [OUT_W-1:0] sine_reg;
    logic signed [OUT_W-1:0] cosine_reg;

    logic signed [SUM_W-1:0]   mag_full;
    logic [MAG_W-1:0]          mag_next;
    logic [SUM_W-1:0]          rnd_full;
    logic [RND_W-1:0]          rnd;
    logic [ROOT_W-1:0]         sat;
    logic signed [OUT_W-1:0]   sine_next;
    logic signed [2*OUT_W-1:0] sq;
    logic [RAD_W-1:0]          v_next;
    logic [RAD_W-1:0]          sq_rem_next  [SQRT_STAGES];
    logic [ROOT_W-1:0]         sq_root_next [SQRT_STAGES];
    logic signed [OUT_W-1:0]   cosine_next;

    always_comb begin
        logic dn_ready;
        dn_ready = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            stg_ready[i] = !valid_reg[i] || dn_ready;
            dn_ready     = stg_ready[i];
        end
    end

    always_comb begin
        mag_full  = in_poly.sum[SUM_W-1] ? -in_poly.sum : in_poly.sum;
        mag_next  = mag_full[MAG_W-1:0];
        // Round half up to Q14 and clamp to one
        rnd_full  = SUM_W'(mag_reg) + (SUM_W'(1) << (RND_SHIFT - 1));
        rnd       = rnd_full[SUM_W-1:RND_SHIFT];
        sat       = (rnd > RND_W'(ONE_Q14)) ? ONE_Q14 : rnd[ROOT_W-1:0];
        sine_next = sgn_reg ? -$signed(OUT_W'(sat)) : $signed(OUT_W'(sat));
        sq        = f2_sine_reg * f2_sine_reg;
        v_next    = ONE_SQ_Q28 - sq[RAD_W-1:0];
    end

    // Restoring square root, SQRT_STEPS root bits per stage
    always_comb begin
        logic [RAD_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [TRIAL_W-1:0] trial;
        int                 b;
        for (int j = 0; j < SQRT_STAGES; j++) begin
            if (j == 0) begin
                rem  = v_reg;
                root = '0;
            end else begin
                rem  = sq_rem_reg[j-1];
                root = sq_root_reg[j-1];
            end
            for (int s = 0; s < SQRT_STEPS; s++) begin
                b = int'(ROOT_W) - 1 - j * int'(SQRT_STEPS) - s;
                if (b >= 0) begin
                    trial = (TRIAL_W'(root) << (b + 1)) + (TRIAL_W'(1) << (2 * b));
                    if (TRIAL_W'(rem) >= trial) begin
                        rem  = RAD_W'(TRIAL_W'(rem) - trial);
                        root = root | (ROOT_W'(1) << b);
                    end
                end
            end
            sq_rem_next[j]  = rem;
            sq_root_next[j] = root;
        end
        cosine_next = sq_negc_reg[SQRT_STAGES-1]
                    ? -$signed(OUT_W'(sq_root_reg[SQRT_STAGES-1]))
                    : $signed(OUT_W'(sq_root_reg[SQRT_STAGES-1]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (stg_ready[i]) begin
                    valid_reg[i] <= (i == 0) ? in_valid : valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_ready[0]) begin
            mag_reg     <= mag_next;
            sgn_reg     <= in_poly.sum[SUM_W-1] ^ in_poly.neg_s;
            f1_negc_reg <= in_poly.neg_c;
        end
        if (stg_ready[1]) begin
            f2_sine_reg <= sine_next;
            f2_negc_reg <= f1_negc_reg;
        end
        if (stg_ready[2]) begin
            v_reg       <= v_next;
            f3_sine_reg <= f2_sine_reg;
            f3_negc_reg <= f2_negc_reg;
        end
        for (int j = 0; j < SQRT_STAGES; j++) begin
            if (stg_ready[SQ0 + j]) begin
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
                sq_sine_reg[j] <= (j == 0) ? f3_sine_reg : sq_sine_reg[j-1];
                sq_negc_reg[j] <= (j == 0) ? f3_negc_reg : sq_negc_reg[j-1];
            end
        end
        if (stg_ready[NSTG-1]) begin
            sine_reg   <= sq_sine_reg[SQRT_STAGES-1];
            cosine_reg <= cosine_next;
        end
    end

    assign in_ready   = stg_ready[0];
    assign out_valid  = valid_reg[NSTG-1];
    assign out_sine   = sine_reg;
    assign out_cosine = cosine_reg;

endmodule

### rtl/core/sine_cosine_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine/cosine unit core
// Pipelined fixed-point sine and cosine of an unsigned Q8.16 angle.
// ----------------------------------------------------------------------------
//
// Usage:
//   s_valid/s_ready/s_angle carry one angle per item (radians, unsigned Q8.16).
//   m_valid/m_ready/m_sine/m_cosine carry one result per item (signed Q2.14,
//   both within plus or minus one).
//   The angle is reduced mod two pi, the upper half-turn is folded, sine comes
//   from an odd series of TERMS terms and cosine from sqrt(1 - sine^2) with the
//   sign of its quadrant.
//   Stages from acceptance to m_valid:
//   4 reduction stages, 4 stages per series term after the first (product,
//   partial products, quotient estimate, correction), 3 rounding stages,
//   4 square root stages at up to 4 root bits each, and the output register.
//   Throughput: one item per cycle, sustained while m_ready is high.
//   Reset clears every stage valid; no result is pending afterwards.
//   When m_ready is low the output register holds its item; earlier stages
//   keep filling bubbles and s_ready drops only once every stage is full.
//
module sine_cosine_unit_core
    import scu_pkg::*;
#(
    parameter int unsigned TERMS = SCU_TERMS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ANGLE_W-1:0]      s_angle,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_sine,
    output logic signed [OUT_W-1:0] m_cosine
);

`include "sine_cosine_unit_core_assert.svh"

    // Series payload after each term; index 0 holds the linear term
    scu_poly_t        poly [TERMS];
    logic [TERMS-1:0] poly_valid;
    logic [TERMS-1:0] poly_ready;

    // Reduce, fold and seed the series with x and x^2
    scu_reduce u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_angle  (s_angle),
        .out_valid (poly_valid[0]),
        .out_ready (poly_ready[0]),
        .out_poly  (poly[0])
    );

    // One pipelined segment per higher-order term, alternating sign
    for (genvar k = 1; k < TERMS; k++) begin : g_term
        scu_term #(
            .K (k)
        ) u_term (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (poly_valid[k-1]),
            .in_ready  (poly_ready[k-1]),
            .in_poly   (poly[k-1]),
            .out_valid (poly_valid[k]),
            .out_ready (poly_ready[k]),
            .out_poly  (poly[k])
        );
    end

    // Round, saturate, square root and drive the result register
    scu_finish u_finish (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (poly_valid[TERMS-1]),
        .in_ready   (poly_ready[TERMS-1]),
        .in_poly    (poly[TERMS-1]),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_sine   (m_sine),
        .out_cosine (m_cosine)
    );

    // Results stay within plus or minus one
    `SCU_ASSERT(a_sine_range, aclk, aresetn, m_valid |-> (m_sine >= -16'sd16384 && m_sine <= 16'sd16384), "sine out of range")
    `SCU_ASSERT(a_cosine_range, aclk, aresetn, m_valid |-> (m_cosine >= -16'sd16384 && m_cosine <= 16'sd16384), "cosine out of range")
    // A saturated sine leaves no room for cosine
    `SCU_ASSERT(a_sat_cosine_zero, aclk, aresetn, (m_valid && (m_sine == 16'sd16384 || m_sine == -16'sd16384)) |-> (m_cosine == 16'sd0), "cosine nonzero at full-scale sine")
    // Reset drops any pending result
    `SCU_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule
